// File: rtl/bhtm_pkg.sv
// bhtm_pkg: shared types and constants of the bucketed hash table
package bhtm_pkg;

  localparam logic [63:0] MIN_VALID_ADDR = 64'h1000;
  localparam int MAX_OUT = 32;
  localparam int BC_W = 11;
  localparam logic [BC_W-1:0] BC_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FRONT  = 2'd2,
    OP_RANDOM = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DIV,
    S_BASE,
    S_RD,
    S_CHK,
    S_PLAN,
    S_WRD,
    S_WWR,
    S_LKEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_hash;
    logic [63:0] entry_addr;
    logic [4:0]  insert_position;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_addr;
    logic        has_match;
    logic        was_present;
    logic        table_changed;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [63:0] addr;
  } cell_t;

endpackage

// File: rtl/bhtm_ram.sv
// bhtm_ram: generic single-port ram with registered read
module bhtm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/bucketed_hash_table_mru.sv
// bucketed_hash_table_mru: set-associative hash table with mru ordering
// steps: a bit-serial bucket modulo, the bucket base, a read and a check of each cell of the
// bucket, then for updates a plan and a read and a write of each rewritten cell, then the result.
// one item at a time through the single ram port.
// after reset a clearing pass empties the ram.
module bucketed_hash_table_mru #(
  parameter int NUM_BUCKETS = 1024,
  parameter int CELLS_PER_BUCKET = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bhtm_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bhtm_pkg::out_word_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [bhtm_pkg::BC_W-1:0] cfg_data
);

  localparam int DEPTH = NUM_BUCKETS * CELLS_PER_BUCKET;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(CELLS_PER_BUCKET);
  localparam int BW = bhtm_pkg::BC_W;
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS_PER_BUCKET - 1);
  localparam logic [5:0] CNT_MAX = 6'(bhtm_pkg::MAX_OUT);

  bhtm_pkg::state_t state, state_next;

  logic [BW-1:0]  bucket_count;
  bhtm_pkg::in_word_t item;
  logic [CW-1:0]  pos;
  logic [BW-1:0]  nb;
  logic [BW-1:0]  rem;
  logic [63:0]    dividend;
  logic [5:0]     bit_cnt;
  logic [AW-1:0]  base;
  logic [CW-1:0]  slot;
  logic [AW-1:0]  clr_addr;

  logic           hit_found, fe_found, fge_found, le_found;
  logic [CW-1:0]  hit_idx, fe_idx, fge_idx, le_idx;
  logic [CW-1:0]  wr_from, wr_to, wr_idx;
  bhtm_pkg::cell_t wr_cell, prev;
  logic           changed;

  logic [63:0]    pend_addr;
  logic           pend_v;
  logic [5:0]     match_cnt;

  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  bhtm_pkg::cell_t mem_wdata, rdata;

  logic           can_push, push;
  bhtm_pkg::out_word_t push_data;
  logic           is_lookup, lk_match, chk_stall;
  logic [BW:0]    shifted;
  bhtm_pkg::cell_t new_cell;
  logic [BW-1:0]  nb_in;
  logic           skip_write;

  bhtm_ram #(
    .WIDTH($bits(bhtm_pkg::cell_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != bhtm_pkg::S_IDLE);
  assign can_push  = !out_valid || !out_stall;
  assign is_lookup = (item.operation == bhtm_pkg::OP_LOOKUP);
  assign lk_match  = is_lookup && (rdata.hash == item.key_hash) &&
                     (rdata.addr >= bhtm_pkg::MIN_VALID_ADDR) && (match_cnt < CNT_MAX);
  assign chk_stall = lk_match && pend_v && !can_push;
  assign shifted   = {rem, dividend[63]};
  assign new_cell  = (wr_idx == wr_from) ? wr_cell : prev;
  // empty rewrite span goes straight to the result
  assign skip_write = ((item.operation == bhtm_pkg::OP_ERASE) && !hit_found) ||
                      ((item.operation == bhtm_pkg::OP_RANDOM) && hit_found &&
                       (hit_idx <= pos));

  // clamp the configured bucket count into 1..NUM_BUCKETS
  always_comb begin
    if (bucket_count == '0) begin
      nb_in = BW'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      nb_in = BW'(NUM_BUCKETS);
    end else begin
      nb_in = bucket_count;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bhtm_pkg::S_CLR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = bhtm_pkg::S_IDLE;
      end
      bhtm_pkg::S_IDLE: begin
        if (in_valid) state_next = bhtm_pkg::S_DIV;
      end
      bhtm_pkg::S_DIV: begin
        if (bit_cnt == '0) state_next = bhtm_pkg::S_BASE;
      end
      bhtm_pkg::S_BASE: state_next = bhtm_pkg::S_RD;
      bhtm_pkg::S_RD:   state_next = bhtm_pkg::S_CHK;
      bhtm_pkg::S_CHK: begin
        if (!chk_stall) begin
          if (slot != LAST_CELL) state_next = bhtm_pkg::S_RD;
          else if (is_lookup) state_next = bhtm_pkg::S_LKEND;
          else state_next = bhtm_pkg::S_PLAN;
        end
      end
      bhtm_pkg::S_PLAN: state_next = skip_write ? bhtm_pkg::S_DONE : bhtm_pkg::S_WRD;
      bhtm_pkg::S_WRD:  state_next = bhtm_pkg::S_WWR;
      bhtm_pkg::S_WWR: begin
        state_next = (wr_idx == wr_to) ? bhtm_pkg::S_DONE : bhtm_pkg::S_WRD;
      end
      bhtm_pkg::S_LKEND, bhtm_pkg::S_DONE: begin
        if (can_push) state_next = bhtm_pkg::S_IDLE;
      end
      default: state_next = bhtm_pkg::S_IDLE;
    endcase
  end

  // ram port and result push
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = AW'(base + AW'(slot));
    mem_wdata = new_cell;
    push      = 1'b0;
    push_data = '0;
    unique case (state)
      bhtm_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      bhtm_pkg::S_WRD: begin
        mem_addr = AW'(base + AW'(wr_idx));
      end
      bhtm_pkg::S_WWR: begin
        mem_we   = 1'b1;
        mem_addr = AW'(base + AW'(wr_idx));
      end
      bhtm_pkg::S_CHK: begin
        if (lk_match && pend_v && can_push) begin
          push = 1'b1;
          push_data.result_addr = pend_addr;
          push_data.has_match   = 1'b1;
        end
      end
      bhtm_pkg::S_LKEND: begin
        push = can_push;
        push_data.result_addr = pend_v ? pend_addr : '0;
        push_data.has_match   = pend_v;
        push_data.last_result = 1'b1;
      end
      bhtm_pkg::S_DONE: begin
        push = can_push;
        push_data.was_present   = hit_found;
        push_data.table_changed = changed;
        push_data.last_result   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bhtm_pkg::S_CLR;
      clr_addr     <= '0;
      bucket_count <= bhtm_pkg::BC_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        bucket_count <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
        out_data  <= push_data;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        bhtm_pkg::S_CLR: clr_addr <= AW'(clr_addr + AW'(1));
        bhtm_pkg::S_IDLE: begin
          item     <= in_data;
          pos      <= (32'(in_data.insert_position) > CELLS_PER_BUCKET - 1) ?
                      LAST_CELL : CW'(in_data.insert_position);
          nb       <= nb_in;
          rem      <= '0;
          dividend <= in_data.key_hash;
          bit_cnt  <= 6'd63;
        end
        bhtm_pkg::S_DIV: begin
          // one quotient bit per cycle, only the remainder is kept
          if (shifted >= {1'b0, nb}) rem <= BW'(shifted - {1'b0, nb});
          else rem <= shifted[BW-1:0];
          dividend <= {dividend[62:0], 1'b0};
          bit_cnt  <= bit_cnt - 6'd1;
        end
        bhtm_pkg::S_BASE: begin
          base      <= AW'(32'(rem) * CELLS_PER_BUCKET);
          slot      <= '0;
          hit_found <= 1'b0;
          fe_found  <= 1'b0;
          fge_found <= 1'b0;
          le_found  <= 1'b0;
          hit_idx   <= '0;
          fe_idx    <= '0;
          fge_idx   <= '0;
          le_idx    <= '0;
          pend_v    <= 1'b0;
          pend_addr <= '0;
          match_cnt <= '0;
          changed   <= 1'b0;
        end
        bhtm_pkg::S_CHK: begin
          if (!chk_stall) begin
            if (lk_match) begin
              pend_v    <= 1'b1;
              pend_addr <= rdata.addr;
              match_cnt <= match_cnt + 6'd1;
            end
            if (!is_lookup) begin
              if (rdata == {item.key_hash, item.entry_addr} && !hit_found) begin
                hit_found <= 1'b1;
                hit_idx   <= slot;
              end
              if (rdata == '0) begin
                if (!fe_found) begin
                  fe_found <= 1'b1;
                  fe_idx   <= slot;
                end
                if (slot >= pos && !fge_found) begin
                  fge_found <= 1'b1;
                  fge_idx   <= slot;
                end
                if (slot < pos) begin
                  le_found <= 1'b1;
                  le_idx   <= slot;
                end
              end
            end
            slot <= CW'(slot + CW'(1));
          end
        end
        bhtm_pkg::S_PLAN: begin
          // span of cells to rewrite
          wr_cell <= (item.operation == bhtm_pkg::OP_ERASE) ? '0 :
                     {item.key_hash, item.entry_addr};
          if (item.operation == bhtm_pkg::OP_ERASE) begin
            wr_from <= hit_idx;
            wr_to   <= hit_idx;
            wr_idx  <= hit_idx;
          end else if (item.operation == bhtm_pkg::OP_FRONT) begin
            wr_from <= '0;
            wr_idx  <= '0;
            wr_to   <= hit_found ? hit_idx : (fe_found ? fe_idx : LAST_CELL);
          end else if (hit_found) begin
            wr_from <= pos;
            wr_idx  <= pos;
            wr_to   <= hit_idx;
          end else if (fge_found) begin
            wr_from <= fge_idx;
            wr_idx  <= fge_idx;
            wr_to   <= fge_idx;
          end else if (le_found) begin
            wr_from <= le_idx;
            wr_idx  <= le_idx;
            wr_to   <= le_idx;
          end else begin
            wr_from <= pos;
            wr_idx  <= pos;
            wr_to   <= LAST_CELL;
          end
        end
        bhtm_pkg::S_WWR: begin
          if (new_cell != rdata) changed <= 1'b1;
          prev   <= rdata;
          wr_idx <= CW'(wr_idx + CW'(1));
        end
        default: ;
      endcase
    end
  end

endmodule

// File: bench/bucketed_hash_table_mru_tb.sv
// bucketed_hash_table_mru_tb: self-checking bench with a bucket-level predictor of the mru table
`timescale 1ns / 1ps

module bucketed_hash_table_mru_tb;

  localparam int NB = 1024;
  localparam int CPB = 32;

  class mru_table_score;
    logic [63:0] hash_mem [NB*CPB];
    logic [63:0] addr_mem [NB*CPB];
    logic [bhtm_pkg::BC_W-1:0] bucket_count;
    bhtm_pkg::out_word_t pending_words[$];
    int errors;
    bit touched;

    function new();
      foreach (hash_mem[i]) begin
        hash_mem[i] = '0;
        addr_mem[i] = '0;
      end
      bucket_count = bhtm_pkg::BC_RESET;
      errors = 0;
    endfunction

    function void add_word(bhtm_pkg::out_word_t r);
      pending_words.insert(pending_words.size(), r);
    endfunction

    function void put(int idx, logic [63:0] h, logic [63:0] a);
      if (hash_mem[idx] != h || addr_mem[idx] != a) touched = 1;
      hash_mem[idx] = h;
      addr_mem[idx] = a;
    endfunction

    // cells from..to-1 move one slot toward the tail
    function void shift_toward_tail(int base, int from, int to);
      for (int d = to; d > from; d--) put(base + d, hash_mem[base + d - 1], addr_mem[base + d - 1]);
    endfunction

    function bit holds(int idx, logic [63:0] h, logic [63:0] a);
      return hash_mem[idx] == h && addr_mem[idx] == a;
    endfunction

    function void note_op(bhtm_pkg::in_word_t w);
      logic [63:0] nb;
      int base, pos, hit, at, n;
      bit done;
      bhtm_pkg::out_word_t r;
      nb = (bucket_count == 0) ? 64'd1 : (bucket_count > NB) ? 64'(NB) : 64'(bucket_count);
      base = int'(w.key_hash % nb) * CPB;
      pos = w.insert_position;
      touched = 0;
      r = '0;
      if (bhtm_pkg::op_t'(w.operation) == bhtm_pkg::OP_LOOKUP) begin
        n = 0;
        for (int i = 0; i < CPB && n < bhtm_pkg::MAX_OUT; i++) begin
          if (hash_mem[base + i] == w.key_hash &&
              addr_mem[base + i] >= bhtm_pkg::MIN_VALID_ADDR) begin
            r.result_addr = addr_mem[base + i];
            r.has_match = 1;
            add_word(r);
            n++;
          end
        end
        if (n == 0) begin
          r.last_result = 1;
          add_word(r);
        end else begin
          pending_words[$].last_result = 1;
        end
        return;
      end
      hit = CPB;
      for (int i = 0; i < CPB; i++) begin
        if (holds(base + i, w.key_hash, w.entry_addr)) begin
          hit = i;
          break;
        end
      end
      case (bhtm_pkg::op_t'(w.operation))
        bhtm_pkg::OP_ERASE: if (hit < CPB) put(base + hit, '0, '0);
        bhtm_pkg::OP_FRONT: begin
          at = hit;
          if (hit == CPB) begin
            for (at = 0; at < CPB; at++) if (holds(base + at, '0, '0)) break;
          end
          if (at >= CPB) at = CPB - 1;
          shift_toward_tail(base, 0, at);
          put(base, w.key_hash, w.entry_addr);
        end
        default: begin
          if (hit < CPB) begin
            if (hit > pos) begin
              shift_toward_tail(base, pos, hit);
              put(base + pos, w.key_hash, w.entry_addr);
            end
          end else begin
            done = 0;
            for (int i = pos; i < CPB && !done; i++)
              if (holds(base + i, '0, '0)) begin
                put(base + i, w.key_hash, w.entry_addr);
                done = 1;
              end
            for (int i = pos; i > 0 && !done; i--)
              if (holds(base + i - 1, '0, '0)) begin
                put(base + i - 1, w.key_hash, w.entry_addr);
                done = 1;
              end
            if (!done) begin
              shift_toward_tail(base, pos, CPB - 1);
              put(base + pos, w.key_hash, w.entry_addr);
            end
          end
        end
      endcase
      r.was_present = (hit < CPB);
      r.table_changed = touched;
      r.last_result = 1;
      add_word(r);
    endfunction

    function void check_word(bhtm_pkg::out_word_t got);
      bhtm_pkg::out_word_t want;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.result_addr !== want.result_addr) begin
        $error("result_addr: expected %h, got %h", want.result_addr, got.result_addr);
        errors++;
      end
      if (got.has_match !== want.has_match) begin
        $error("has_match: expected %b, got %b", want.has_match, got.has_match);
        errors++;
      end
      if (got.was_present !== want.was_present) begin
        $error("was_present: expected %b, got %b", want.was_present, got.was_present);
        errors++;
      end
      if (got.table_changed !== want.table_changed) begin
        $error("table_changed: expected %b, got %b", want.table_changed, got.table_changed);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %b, got %b", want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  bhtm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  bhtm_pkg::out_word_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [bhtm_pkg::BC_W-1:0] cfg_data = '0;

  mru_table_score sb = new();
  bit quiet = 0;
  logic [63:0] hash_pool [4];
  logic [63:0] addr_pool [8];

  bucketed_hash_table_mru #(.NUM_BUCKETS(NB), .CELLS_PER_BUCKET(CPB)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 15);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(out_data);
  end

  // called at a falling edge, returns at a falling edge with in_valid left high
  task automatic send(bhtm_pkg::op_t op, logic [63:0] h, logic [63:0] a, logic [4:0] p);
    bhtm_pkg::in_word_t w;
    w.operation = op;
    w.key_hash = h;
    w.entry_addr = a;
    w.insert_position = p;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(w);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_bucket_count(logic [bhtm_pkg::BC_W-1:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.bucket_count = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_word();
    bhtm_pkg::op_t op;
    logic [63:0] h, a;
    int pick;
    pick = $urandom_range(0, 99);
    op = (pick < 25) ? bhtm_pkg::OP_LOOKUP : (pick < 40) ? bhtm_pkg::OP_ERASE :
         (pick < 70) ? bhtm_pkg::OP_FRONT : bhtm_pkg::OP_RANDOM;
    // mostly pooled keys so buckets fill and pairs recur; the rest is noise
    if ($urandom_range(0, 9) == 0) h = {$urandom, $urandom};
    else h = hash_pool[$urandom_range(0, 3)];
    if ($urandom_range(0, 1) == 0) a = addr_pool[$urandom_range(0, 7)];
    else a = {32'($urandom_range(0, 1) ? $urandom : 0), $urandom};
    send(op, h, a, 5'($urandom_range(0, 31)));
  endtask

  function automatic int j_small(int k);
    return k * 3;
  endfunction

  initial begin
    logic [bhtm_pkg::BC_W-1:0] settings [6];
    settings = '{11'd1, 11'd0, 11'd2047, 11'd2, 11'd1024, 11'd5};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed part at the reset bucket count
    send(bhtm_pkg::OP_LOOKUP, 64'h0, 64'h0, 5'd0);
    send(bhtm_pkg::OP_FRONT, 64'h0, 64'h0, 5'd0);
    send(bhtm_pkg::OP_RANDOM, 64'h0, 64'h0, 5'd31);
    send(bhtm_pkg::OP_FRONT, '1, '1, 5'd0);
    send(bhtm_pkg::OP_LOOKUP, '1, 64'h0, 5'd0);
    send(bhtm_pkg::OP_FRONT, '1, 64'h0fff, 5'd0);
    send(bhtm_pkg::OP_FRONT, '1, 64'h1000, 5'd0);
    send(bhtm_pkg::OP_LOOKUP, '1, 64'h0, 5'd31);
    send(bhtm_pkg::OP_FRONT, '1, '1, 5'd0);
    send(bhtm_pkg::OP_ERASE, '1, 64'h0fff, 5'd0);
    send(bhtm_pkg::OP_ERASE, '1, 64'h0fff, 5'd0);
    send(bhtm_pkg::OP_RANDOM, '1, 64'h2000, 5'd31);
    send(bhtm_pkg::OP_RANDOM, '1, 64'h3000, 5'd0);
    send(bhtm_pkg::OP_RANDOM, '1, 64'h2000, 5'd1);
    send(bhtm_pkg::OP_RANDOM, '1, 64'h1000, 5'd15);
    send(bhtm_pkg::OP_RANDOM, '1, 64'h3000, 5'd10);
    send(bhtm_pkg::OP_LOOKUP, '1, 64'h0, 5'd0);
    send(bhtm_pkg::OP_ERASE, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd21);
    send(bhtm_pkg::OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 5'd10);
    send(bhtm_pkg::OP_LOOKUP, 64'h0, 64'h0, 5'd0);
    drain();

    foreach (settings[k]) begin
      write_bucket_count(settings[k]);
      if (k == 5) quiet = 1;
      foreach (hash_pool[j]) hash_pool[j] = {$urandom, $urandom};
      hash_pool[0] = 64'(j_small(k));
      foreach (addr_pool[j]) addr_pool[j] = {$urandom, $urandom};
      addr_pool[0] = 64'h0;
      addr_pool[1] = 64'h0fff;
      addr_pool[2] = 64'h1000;
      addr_pool[3] = '1;
      repeat (32) random_word();
      drain();
    end

    if (sb.pending_words.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
